// File: sv/rsm_pkg.sv
package rsm_pkg;

    // pattern depth and row limit
    localparam int PATTERN_MAX = 16;
    localparam int ROW_MAX     = 65536;

    // derived widths
    localparam int PAT_LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int PAT_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int ROW_CNT_W  = $clog2(ROW_MAX + 1);

    // fixed field widths
    localparam int VALUE_W    = 32;
    localparam int ROW_NUM_W  = 17;

    typedef enum logic [1:0] {
        REQ_NEW_QUERY = 2'd0,
        REQ_PATTERN   = 2'd1,
        REQ_MATRIX    = 2'd2,
        REQ_EMPTY_ROW = 2'd3
    } req_t;

    typedef struct packed {
        req_t                      req_type;
        logic signed [VALUE_W-1:0] value;
        logic                      row_end;
    } item_t;

    typedef struct packed {
        logic                 valid;
        logic [ROW_NUM_W-1:0] row_number;
    } result_t;

endpackage

// File: sv/rsm_match_core.sv
module rsm_match_core
    import rsm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_fire,
    input  item_t   item,
    output result_t result
);

    logic [VALUE_W-1:0]     pat_store_reg [PATTERN_MAX];
    logic [PAT_LEN_W-1:0]   pat_len_reg, pat_len_next;
    logic                   pat_ovf_reg, pat_ovf_next;
    logic [PATTERN_MAX-1:0] partial_reg, partial_next;
    logic                   row_hit_reg, row_hit_next;
    logic [ROW_CNT_W-1:0]   row_cnt_reg, row_cnt_next;

    logic [PATTERN_MAX-1:0] match_vec;
    logic                   full_hit;
    logic                   hit_now;
    logic                   pat_full;
    logic                   cnt_room;
    logic [PAT_IDX_W-1:0]   last_idx;
    logic [PAT_IDX_W-1:0]   wr_idx;

    // partial-match vector for the incoming element
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            logic prev;
            prev = (k == 0) ? 1'b1 : partial_reg[(k > 0) ? k - 1 : 0];
            match_vec[k] = (PAT_LEN_W'(k) < pat_len_reg) && prev
                           && (pat_store_reg[k] == item.value);
        end
    end

    assign last_idx = PAT_IDX_W'(pat_len_reg - PAT_LEN_W'(1));
    assign wr_idx   = PAT_IDX_W'(pat_len_reg);
    assign full_hit = (pat_len_reg == '0) || match_vec[last_idx];
    assign hit_now  = row_hit_reg || (!pat_ovf_reg && full_hit);
    assign pat_full = (pat_len_reg == PAT_LEN_W'(PATTERN_MAX));
    assign cnt_room = (row_cnt_reg < ROW_CNT_W'(ROW_MAX));

    always_comb begin
        pat_len_next      = pat_len_reg;
        pat_ovf_next      = pat_ovf_reg;
        partial_next      = partial_reg;
        row_hit_next      = row_hit_reg;
        row_cnt_next      = row_cnt_reg;
        result.valid      = 1'b0;
        result.row_number = ROW_NUM_W'(row_cnt_reg + ROW_CNT_W'(1));
        if (item_fire) begin
            case (item.req_type)
                REQ_NEW_QUERY: begin
                    pat_len_next = '0;
                    pat_ovf_next = 1'b0;
                    row_cnt_next = '0;
                    partial_next = '0;
                    row_hit_next = 1'b0;
                end
                REQ_PATTERN: begin
                    if (pat_full) begin
                        pat_ovf_next = 1'b1;
                    end else begin
                        pat_len_next = pat_len_reg + PAT_LEN_W'(1);
                    end
                end
                REQ_MATRIX: begin
                    partial_next = match_vec;
                    row_hit_next = hit_now;
                    if (item.row_end) begin
                        if (cnt_room) begin
                            row_cnt_next = row_cnt_reg + ROW_CNT_W'(1);
                            result.valid = hit_now;
                        end
                        partial_next = '0;
                        row_hit_next = 1'b0;
                    end
                end
                default: begin
                    partial_next = '0;
                    row_hit_next = 1'b0;
                    if (cnt_room) begin
                        row_cnt_next = row_cnt_reg + ROW_CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // pattern entries, written in order after a new query
    always_ff @(posedge aclk) begin
        if (item_fire && item.req_type == REQ_PATTERN && !pat_full) begin
            pat_store_reg[wr_idx] <= item.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg <= '0;
            pat_ovf_reg <= 1'b0;
            partial_reg <= '0;
            row_hit_reg <= 1'b0;
            row_cnt_reg <= '0;
        end else begin
            pat_len_reg <= pat_len_next;
            pat_ovf_reg <= pat_ovf_next;
            partial_reg <= partial_next;
            row_hit_reg <= row_hit_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pat_len_reg <= PAT_LEN_W'(PATTERN_MAX))
        else $error("pattern length past depth");

    a_new_query_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && item.req_type == REQ_NEW_QUERY)
        |=> (pat_len_reg == '0 && row_cnt_reg == '0 && !pat_ovf_reg && partial_reg == '0))
        else $error("new query left state behind");

    a_result_at_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        result.valid |-> (item_fire && item.req_type == REQ_MATRIX && item.row_end))
        else $error("result outside a row end");

    a_overflow_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (pat_ovf_reg && !row_hit_reg && item_fire && item.req_type != REQ_PATTERN)
        |=> !row_hit_reg)
        else $error("row hit while pattern overflowed");

endmodule

// File: sv/row_sequence_matcher.sv
// channel  | ports                                    | handshake
// ---------+------------------------------------------+------------------
// input    | s_req_type, s_value, s_row_end           | s_valid / s_ready
// result   | m_row_number                             | m_valid / m_ready
//
// one item per cycle sustained unless the result stalls: input register,
// one pass through the match core, result register, which drives m_valid
// synchronous active-low reset clears control state; the pattern entries
// are not cleared and are written again after every new query
// a stalled result holds the result register and the item behind it;
// s_ready drops once the input register is full behind a stalled result
module row_sequence_matcher
    import rsm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_req_type,
    input  logic signed [VALUE_W-1:0] s_value,
    input  logic                      s_row_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ROW_NUM_W-1:0]      m_row_number
);

    // input register
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_NUM_W-1:0] out_row_reg;

    logic    out_free;
    logic    process;
    item_t   s_item;
    result_t core_result;

    // result register can take a new value this cycle
    assign out_free = !out_valid_reg || m_ready;
    // the held item goes through the core when its result has somewhere to go
    assign process  = in_valid_reg && out_free;
    // input register is free, or is emptying this cycle
    assign s_ready  = !in_valid_reg || out_free;

    assign s_item.req_type = req_t'(s_req_type);
    assign s_item.value    = s_value;
    assign s_item.row_end  = s_row_end;

    rsm_match_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (process),
        .item      (in_item_reg),
        .result    (core_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = process && core_result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (process && core_result.valid) begin
            out_row_reg <= core_result.row_number;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_row_number = out_row_reg;

    a_hold_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("held item lost while result stalled");

    a_row_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_row_reg != '0))
        else $error("row number zero");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(out_valid_reg)) |-> $past(process))
        else $error("result without a processed item");

endmodule

// File: bench/row_sequence_matcher_test.sv
module row_sequence_matcher_test;
    import rsm_pkg::*;

    // generous ceiling: the row limit sweep alone is about 66k items
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_ITEMS_PER_PHASE = 400;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_req_type = REQ_NEW_QUERY;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      s_row_end = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [ROW_NUM_W-1:0]      m_row_number;

    row_sequence_matcher dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_value      (s_value),
        .s_row_end    (s_row_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_number (m_row_number)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // matcher state as the testbench sees it
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] pat_vals [PATTERN_MAX];
    int                        pat_len = 0;
    bit                        pat_over = 1'b0;
    logic [PATTERN_MAX-1:0]    prefix_hits = '0;   // bit k: pattern[0..k] ends here
    bit                        hit_in_row = 1'b0;
    int                        rows_counted = 0;

    // row numbers still owed by the block, oldest first
    bit [ROW_NUM_W-1:0] expected_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int rows_checked = 0;
    int error_count = 0;
    int cycle_count = 0;

    function automatic void note_mismatch(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // append a row number to the owed list
    function automatic void queue_row(input bit [ROW_NUM_W-1:0] num);
        expected_rows = {expected_rows, num};
    endfunction

    // work out what one accepted item does to the row state; got/num carry
    // the row report it causes, if any
    function automatic void predict_row_report(input req_t r, input logic signed [31:0] v,
                                               input bit e, output bit got,
                                               output bit [ROW_NUM_W-1:0] num);
        logic [PATTERN_MAX-1:0] nxt;
        bit prev;
        got = 1'b0;
        num = '0;
        case (r)
            REQ_NEW_QUERY: begin
                pat_len = 0;
                pat_over = 1'b0;
                rows_counted = 0;
                prefix_hits = '0;
                hit_in_row = 1'b0;
            end
            REQ_PATTERN: begin
                if (pat_len < PATTERN_MAX) begin
                    pat_vals[pat_len] = v;
                    pat_len++;
                end else begin
                    pat_over = 1'b1;
                end
            end
            REQ_MATRIX: begin
                // shift every live prefix one element further
                nxt = '0;
                for (int k = 0; k < pat_len; k++) begin
                    prev = (k == 0) ? 1'b1 : prefix_hits[k-1];
                    if (prev && pat_vals[k] == v) begin
                        nxt[k] = 1'b1;
                    end
                end
                prefix_hits = nxt;
                // an empty pattern matches as soon as the row has an element
                if (!pat_over && (pat_len == 0 || nxt[pat_len-1])) begin
                    hit_in_row = 1'b1;
                end
                if (e) begin
                    // rows past the limit are neither counted nor reported
                    if (rows_counted < ROW_MAX) begin
                        rows_counted++;
                        if (hit_in_row) begin
                            got = 1'b1;
                            num = ROW_NUM_W'(rows_counted);
                        end
                    end
                    prefix_hits = '0;
                    hit_in_row = 1'b0;
                end
            end
            default: begin
                // empty row: drops any open row and counts as one row
                prefix_hits = '0;
                hit_in_row = 1'b0;
                if (rows_counted < ROW_MAX) begin
                    rows_counted++;
                end
            end
        endcase
    endfunction

    // drive one item, hold it until accepted, then predict from it
    task automatic send_item(input req_t r, input logic signed [31:0] v, input bit e,
                             output bit got, output bit [ROW_NUM_W-1:0] num);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= r;
        s_value    <= v;
        s_row_end  <= e;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        predict_row_report(r, v, e, got, num);
    endtask

    task automatic send_and_predict(input req_t r, input logic signed [31:0] v, input bit e);
        bit got;
        bit [ROW_NUM_W-1:0] num;
        send_item(r, v, e, got, num);
        if (got) begin
            queue_row(num);
        end
    endtask

    // extremes and small values show up often so that rows repeat values
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // one query: new query, plen pattern elements, then nrows rows drawn from a
    // four-value alphabet, about half of them carrying the pattern somewhere;
    // rows get sprinkled with mid-row pattern elements, empty rows and noise
    task automatic run_query(input int plen, input int nrows);
        logic signed [31:0] alpha [4];
        logic signed [31:0] pat [$];
        logic signed [31:0] row [$];
        logic signed [31:0] v;
        int len, pos, sel;
        bit embed;
        for (int j = 0; j < 4; j++) alpha[j] = pick_value();
        send_and_predict(REQ_NEW_QUERY, $urandom, 1'($urandom_range(1)));
        for (int j = 0; j < plen; j++) begin
            v = alpha[$urandom_range(3)];
            pat = {pat, v};
            send_and_predict(REQ_PATTERN, pat[j], 1'($urandom_range(1)));
        end
        repeat (nrows) begin
            if ($urandom_range(15) == 0) begin
                send_and_predict(REQ_EMPTY_ROW, $urandom, 1'($urandom_range(1)));
            end else begin
                len = $urandom_range(12, 1);
                embed = ($urandom_range(1) == 1) && (pat.size() > 0);
                if (embed) len += pat.size();
                row.delete();
                for (int j = 0; j < len; j++) begin
                    v = ($urandom_range(9) == 0) ? $urandom : alpha[$urandom_range(3)];
                    row = {row, v};
                end
                if (embed) begin
                    pos = $urandom_range(len - pat.size());
                    for (int j = 0; j < pat.size(); j++) row[pos + j] = pat[j];
                end
                for (int j = 0; j < len; j++) begin
                    sel = $urandom_range(99);
                    if (sel < 3) begin
                        // pattern grows while the row is open
                        v = pick_value();
                        pat = {pat, v};
                        send_and_predict(REQ_PATTERN, v, 1'($urandom_range(1)));
                    end else if (sel < 5) begin
                        // empty row cuts the open row short
                        send_and_predict(REQ_EMPTY_ROW, $urandom, 1'($urandom_range(1)));
                    end else if (sel < 7) begin
                        send_and_predict(req_t'($urandom_range(3)), $urandom,
                                         1'($urandom_range(1)));
                    end
                    send_and_predict(REQ_MATRIX, row[j], j == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // directed items; typed rows carry a result read straight off the
    // behavior, the rest are checked against the predictor
    // ------------------------------------------------------------------
    typedef struct packed {
        req_t               req;
        logic signed [31:0] val;
        bit                 last;
        bit                 typed;
        bit                 hit;
        bit [ROW_NUM_W-1:0] row;
    } step_t;

    localparam int DIRECTED_LEN = 21;
    localparam step_t DIRECTED [DIRECTED_LEN] = '{
        // empty pattern right after reset: any non-empty row hits
        '{REQ_MATRIX,    32'sd5,           1'b1, 1'b1, 1'b1, 17'd1},
        // an empty row never hits, even with an empty pattern
        '{REQ_EMPTY_ROW, 32'sd0,           1'b0, 1'b1, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sh8000_0000,   1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sh7fff_ffff,   1'b1, 1'b1, 1'b1, 17'd3},
        // new query with its ignored fields all ones
        '{REQ_NEW_QUERY, -32'sd1,          1'b1, 1'b0, 1'b0, 17'd0},
        '{REQ_PATTERN,   32'sh8000_0000,   1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_PATTERN,   32'sh7fff_ffff,   1'b1, 1'b0, 1'b0, 17'd0},
        // min,max found after a false start on max
        '{REQ_MATRIX,    32'sh7fff_ffff,   1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sh8000_0000,   1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sh7fff_ffff,   1'b1, 1'b1, 1'b1, 17'd1},
        // empty row while a row is open
        '{REQ_MATRIX,    32'sd0,           1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_EMPTY_ROW, 32'sh7fff_ffff,   1'b1, 1'b1, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sh8000_0000,   1'b1, 1'b0, 1'b0, 17'd0},
        // pattern element arrives inside an open row
        '{REQ_MATRIX,    32'sh8000_0000,   1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_PATTERN,   32'sd7,           1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sh7fff_ffff,   1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sd7,           1'b1, 1'b0, 1'b0, 17'd0},
        '{REQ_NEW_QUERY, 32'sd0,           1'b0, 1'b0, 1'b0, 17'd0},
        '{REQ_PATTERN,   -32'sd1,          1'b1, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    -32'sd1,          1'b1, 1'b0, 1'b0, 17'd0},
        '{REQ_MATRIX,    32'sd1,           1'b1, 1'b0, 1'b0, 17'd0}
    };

    // idle mixes per random phase: none, sender, receiver, both
    localparam int PHASES = 4;
    localparam int SEND_IDLE [PHASES] = '{0, 70, 0, 27};
    localparam int RECV_STALL [PHASES] = '{0, 0, 70, 27};

    // ------------------------------------------------------------------
    // result side: random backpressure and in-order checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_side
        bit [ROW_NUM_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            rows_checked++;
            if (expected_rows.size() == 0) begin
                note_mismatch($sformatf("unexpected row report: got %0d, none expected",
                                        m_row_number));
            end else begin
                want = expected_rows.pop_front();
                if (m_row_number !== want) begin
                    note_mismatch($sformatf("row_number mismatch: expected %0d, got %0d",
                                            want, m_row_number));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_rows.size());
            $display("row_sequence_matcher_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit got;
        bit [ROW_NUM_W-1:0] num;
        int goal;
        int plen;
        int sel;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            send_item(DIRECTED[i].req, DIRECTED[i].val, DIRECTED[i].last, got, num);
            if (DIRECTED[i].typed) begin
                if (DIRECTED[i].hit) queue_row(DIRECTED[i].row);
            end else if (got) begin
                queue_row(num);
            end
        end

        // pattern one past the store depth: nothing may hit afterwards
        run_query(PATTERN_MAX + 1, 4);

        // random queries under each idle mix
        goal = items_sent;
        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            goal += RANDOM_ITEMS_PER_PHASE;
            while (items_sent < goal) begin
                sel = $urandom_range(99);
                if (sel < 8) plen = 0;
                else if (sel < 16) plen = PATTERN_MAX + $urandom_range(3, 1);
                else if (sel < 36) plen = PATTERN_MAX;
                else plen = $urandom_range(PATTERN_MAX - 1, 1);
                run_query(plen, $urandom_range(6, 1));
            end
        end

        // row counter saturation: fill up to the last countable row with empty
        // rows, then rows at and past the limit with an empty pattern
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_and_predict(REQ_NEW_QUERY, $urandom, 1'($urandom_range(1)));
        repeat (ROW_MAX - 1) send_and_predict(REQ_EMPTY_ROW, $urandom, 1'($urandom_range(1)));
        send_and_predict(REQ_MATRIX, $urandom, 1'b1);   // last counted row
        send_and_predict(REQ_MATRIX, $urandom, 1'b1);   // past the limit
        send_and_predict(REQ_EMPTY_ROW, $urandom, 1'($urandom_range(1)));
        send_and_predict(REQ_MATRIX, $urandom, 1'b1);

        s_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d items sent (directed, overflow, four idle mixes, row limit sweep)",
                 items_sent);
        $display("%0d row reports checked, %0d mismatches", rows_checked, error_count);
        if (error_count == 0) begin
            $display("row_sequence_matcher_test: clean");
        end else begin
            $display("row_sequence_matcher_test: errors");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rsm_pkg.sv
sv/rsm_match_core.sv
sv/row_sequence_matcher.sv
bench/row_sequence_matcher_test.sv
